// ===== rtl/chl_pkg.sv =====
package chl_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int LINK_W      = IDX_W + 1;
	localparam int CFG_W       = 13;
	localparam int OP_W        = 2;
	localparam int KEY_W       = 64;
	localparam int STAT_W      = 2;
	localparam int OUT_IDX_W   = 12;

	localparam int HASH_W      = 17;
	localparam int MOD_BITS    = 4;
	localparam int MOD_ROUNDS  = (HASH_W + MOD_BITS - 1) / MOD_BITS;
	localparam int DIV_W       = MOD_ROUNDS * MOD_BITS;
	localparam int RND_W       = $clog2(MOD_ROUNDS);

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] bucket;
	} chl_cmd_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
	endfunction

	function automatic logic [CNT_W-1:0] eff_count(input logic [CFG_W-1:0] c);
		return (c > CFG_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : CNT_W'(c);
	endfunction

endpackage

// ===== rtl/chl_in_if.sv =====
interface chl_in_if;
	import chl_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [KEY_W-1:0] key_name;

	modport source(output valid, output operation, output key_name, input ready);
	modport sink(input valid, input operation, input key_name, output ready);

endinterface

// ===== rtl/chl_out_if.sv =====
interface chl_out_if;
	import chl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STAT_W-1:0]    status;
	logic [OUT_IDX_W-1:0] entry_index;

	modport source(output valid, output status, output entry_index, input ready);
	modport sink(input valid, input status, input entry_index, output ready);

endinterface

// ===== rtl/chl_front.sv =====
module chl_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [chl_pkg::CFG_W-1:0] entry_count,
	chl_in_if.sink                    in_ch,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output chl_pkg::chl_cmd_t         cmd
);
	import chl_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_MOD, F_PUSH} fstate_t;

	fstate_t          state_q;
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic [DIV_W-1:0] div_q;
	logic [CNT_W-1:0] rem_q;
	logic [RND_W-1:0] rnd_q;
	logic [CNT_W-1:0] ec;
	logic [CNT_W-1:0] rem_nxt;
	logic             need_mod;

	function automatic logic [HASH_W-1:0] name_hash(input logic [KEY_W-1:0] k);
		logic [HASH_W-1:0] h;
		logic              stop;
		h    = HASH_W'(to_upper(k[7:0]));
		stop = 1'b0;
		for (int i = 1; i < 8; i++) begin
			if (i < 7 && k[8*i +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				h = ((i == 1) ? (h << 1) + h : (h << 1)) + HASH_W'(to_upper(k[8*i +: 8]));
		end
		return h;
	endfunction

	assign ec        = eff_count(entry_count);
	assign need_mod  = (in_ch.operation == OP_INSERT || in_ch.operation == OP_LOOKUP)
			&& ec != '0;
	assign in_ch.ready = (state_q == F_IDLE);
	assign cmd_valid   = (state_q == F_PUSH);
	assign cmd         = '{op: op_q, key: key_q, bucket: rem_q[IDX_W-1:0]};

	always_comb begin
		rem_nxt = rem_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			rem_nxt = {rem_nxt[CNT_W-2:0], div_q[DIV_W-1-i]};
			if (rem_nxt >= ec)
				rem_nxt = rem_nxt - ec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			op_q    <= '0;
			key_q   <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			rnd_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_ch.valid) begin
						op_q    <= in_ch.operation;
						key_q   <= in_ch.key_name;
						div_q   <= DIV_W'(name_hash(in_ch.key_name));
						rem_q   <= '0;
						rnd_q   <= '0;
						state_q <= need_mod ? F_MOD : F_PUSH;
					end
				end
				F_MOD: begin
					rem_q <= rem_nxt;
					div_q <= div_q << MOD_BITS;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == RND_W'(MOD_ROUNDS - 1))
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (cmd_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/chl_fifo.sv =====
module chl_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  chl_pkg::chl_cmd_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output chl_pkg::chl_cmd_t pop_data
);
	import chl_pkg::*;

	chl_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// ===== rtl/chl_back.sv =====
module chl_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [chl_pkg::CFG_W-1:0] entry_count,
	input  logic                      cmd_valid,
	output logic                      cmd_ready,
	input  chl_pkg::chl_cmd_t         cmd,
	chl_out_if.source                 out_ch
);
	import chl_pkg::*;

	typedef enum logic [2:0] {B_INIT, B_IDLE, B_HEAD, B_ENTRY, B_RESP} bstate_t;

	typedef struct packed {
		logic [KEY_W-1:0]  name;
		logic [LINK_W-1:0] link;
		logic [IDX_W-1:0]  bucket;
	} entry_t;

	logic [IDX_W-1:0] head_mem [MAX_ENTRIES];
	entry_t           entry_mem [MAX_ENTRIES];

	bstate_t              state_q;
	chl_cmd_t             cmd_q;
	logic [CNT_W-1:0]     ins_cnt_q;
	logic [IDX_W-1:0]     cur_q;
	logic                 first_q;
	logic [STAT_W-1:0]    res_status_q;
	logic [OUT_IDX_W-1:0] res_index_q;
	logic                 out_valid_q;
	logic [STAT_W-1:0]    out_status_q;
	logic [OUT_IDX_W-1:0] out_index_q;
	logic [IDX_W-1:0]     head_rd_q;
	entry_t               ent_rd_q;
	logic [IDX_W-1:0]     init_idx_q;

	logic [CNT_W-1:0]  ec;
	logic [IDX_W-1:0]  slot;
	logic              head_live;
	logic              head_stale;
	logic              name_hit;
	logic              link_end;
	logic              ins_write;
	logic [LINK_W-1:0] link_w;
	logic              head_re;
	logic              head_we;
	logic [IDX_W-1:0]  head_wa;
	logic [IDX_W-1:0]  head_wd;
	logic              ent_re;
	logic [IDX_W-1:0]  ent_ra;

	function automatic logic names_eq(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
		logic eq;
		logic stop;
		eq   = 1'b1;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (!stop) begin
				if (to_upper(a[8*i +: 8]) != to_upper(b[8*i +: 8])) begin
					eq   = 1'b0;
					stop = 1'b1;
				end else if (a[8*i +: 8] == 8'd0) begin
					stop = 1'b1;
				end
			end
		end
		return eq;
	endfunction

	assign ec         = eff_count(entry_count);
	assign slot       = ins_cnt_q[IDX_W-1:0];
	assign head_live  = CNT_W'(head_rd_q) < ins_cnt_q;
	assign head_stale = first_q && (ent_rd_q.bucket != cmd_q.bucket);
	assign name_hit   = names_eq(ent_rd_q.name, cmd_q.key);
	assign link_end   = ent_rd_q.link >= LINK_W'(MAX_ENTRIES);

	assign cmd_ready = (state_q == B_IDLE);
	assign head_re   = (state_q == B_IDLE) && cmd_valid;
	assign head_we   = ins_write || (state_q == B_INIT);
	assign head_wa   = (state_q == B_INIT) ? init_idx_q : cmd_q.bucket;
	assign head_wd   = (state_q == B_INIT) ? '0 : slot;

	always_comb begin
		ins_write = 1'b0;
		link_w    = LINK_W'(MAX_ENTRIES);
		ent_re    = 1'b0;
		ent_ra    = head_rd_q;
		if (state_q == B_HEAD) begin
			if (!head_live)
				ins_write = (cmd_q.op == OP_INSERT);
			else
				ent_re = 1'b1;
		end else if (state_q == B_ENTRY) begin
			if (cmd_q.op == OP_INSERT) begin
				ins_write = 1'b1;
				if (!head_stale)
					link_w = LINK_W'(cur_q);
			end else if (!head_stale && !name_hit && !link_end) begin
				ent_re = 1'b1;
				ent_ra = ent_rd_q.link[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_re)
			head_rd_q <= head_mem[cmd.bucket];
		if (head_we)
			head_mem[head_wa] <= head_wd;
	end

	always_ff @(posedge clk) begin
		if (ent_re)
			ent_rd_q <= entry_mem[ent_ra];
		if (ins_write)
			entry_mem[slot] <= '{name: cmd_q.key, link: link_w, bucket: cmd_q.bucket};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_INIT;
			cmd_q        <= '0;
			ins_cnt_q    <= '0;
			cur_q        <= '0;
			first_q      <= 1'b0;
			res_status_q <= ST_OK;
			res_index_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_index_q  <= '0;
			init_idx_q   <= '0;
		end else begin
			if (out_valid_q && out_ch.ready && state_q != B_RESP)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (init_idx_q == '1)
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (cmd_valid) begin
						cmd_q       <= cmd;
						res_index_q <= '0;
						unique case (cmd.op)
							OP_CLEAR: begin
								ins_cnt_q    <= '0;
								res_status_q <= ST_OK;
								state_q      <= B_RESP;
							end
							OP_INSERT: begin
								if (ins_cnt_q >= ec) begin
									res_status_q <= ST_FULL;
									state_q      <= B_RESP;
								end else begin
									state_q <= B_HEAD;
								end
							end
							OP_LOOKUP: begin
								if (ec == '0) begin
									res_status_q <= ST_NOT_FOUND;
									state_q      <= B_RESP;
								end else begin
									state_q <= B_HEAD;
								end
							end
							default: begin
								res_status_q <= ST_NOT_FOUND;
								state_q      <= B_RESP;
							end
						endcase
					end
				end
				B_HEAD: begin
					if (!head_live) begin
						if (cmd_q.op == OP_INSERT) begin
							ins_cnt_q    <= ins_cnt_q + 1'b1;
							res_status_q <= ST_OK;
							res_index_q  <= OUT_IDX_W'(slot);
						end else begin
							res_status_q <= ST_NOT_FOUND;
						end
						state_q <= B_RESP;
					end else begin
						cur_q   <= head_rd_q;
						first_q <= 1'b1;
						state_q <= B_ENTRY;
					end
				end
				B_ENTRY: begin
					if (cmd_q.op == OP_INSERT) begin
						ins_cnt_q    <= ins_cnt_q + 1'b1;
						res_status_q <= ST_OK;
						res_index_q  <= OUT_IDX_W'(slot);
						state_q      <= B_RESP;
					end else if (head_stale) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= B_RESP;
					end else if (name_hit) begin
						res_status_q <= ST_OK;
						res_index_q  <= OUT_IDX_W'(cur_q);
						state_q      <= B_RESP;
					end else if (link_end) begin
						res_status_q <= ST_NOT_FOUND;
						state_q      <= B_RESP;
					end else begin
						cur_q   <= ent_rd_q.link[IDX_W-1:0];
						first_q <= 1'b0;
					end
				end
				B_RESP: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_index_q  <= res_index_q;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.status      = out_status_q;
	assign out_ch.entry_index = out_index_q;

endmodule

// ===== rtl/chained_hash_name_lookup_unit.sv =====
// channel   dir  handshake     payload
// in_ch     in   valid/ready   operation[1:0], key_name[63:0]
// out_ch    out  valid/ready   status[1:0], entry_index[11:0]
// cfg       in   cfg_wr_en     cfg_wr_data[12:0] (entry_count)
//
// Front: an insert or lookup is hashed, then passes a five-round remainder unit at 4 bits
// per round; other items, and any item while entry_count is zero, skip that unit. Back:
// clear, unknown, table full or zero count go to the response; else a bucket head read, then
// one step per chain entry visited, each one entry memory read. Reset runs a pass that fills
// the bucket heads; clear takes effect at once, heads are checked against the insert count
// and the stored bucket of the entry they name. A two-item queue parts front and back.
module chained_hash_name_lookup_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [chl_pkg::CFG_W-1:0] cfg_wr_data,
	chl_in_if.sink                    in_ch,
	chl_out_if.source                 out_ch
);
	import chl_pkg::*;

	logic [CFG_W-1:0] entry_count_q;
	logic             f_valid;
	logic             f_ready;
	chl_cmd_t         f_cmd;
	logic             b_valid;
	logic             b_ready;
	chl_cmd_t         b_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_count_q <= '0;
		else if (cfg_wr_en)
			entry_count_q <= cfg_wr_data;
	end

	chl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count_q),
		.in_ch       (in_ch),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd         (f_cmd)
	);

	chl_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	chl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_count (entry_count_q),
		.cmd_valid   (b_valid),
		.cmd_ready   (b_ready),
		.cmd         (b_cmd),
		.out_ch      (out_ch)
	);

endmodule
